/* src/csvtok_pkg.sv */
// Shared types, codes and constants for the CSV byte tokenizer.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package csvtok_pkg;

  localparam int ROW_BITS_DEF = 24;
  localparam int COL_BITS_DEF = 12;
  localparam int QDEPTH_DEF   = 4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  typedef enum logic [1:0] {
    K_DATA    = 2'd0,
    K_FINISH  = 2'd1,
    K_RESTART = 2'd2,
    K_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    EV_CONTENT = 2'd0,
    EV_END     = 2'd1,
    EV_ERROR   = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    PH_LINE     = 3'd0,
    PH_FSTART   = 3'd1,
    PH_PLAIN    = 3'd2,
    PH_QUOTED   = 3'd3,
    PH_QSEEN    = 3'd4,
    PH_AFTER_CR = 3'd5,
    PH_ERROR    = 3'd6
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       is_quote;
    logic       is_delim;
    logic       is_cr;
    logic       is_lf;
  } token_t;

endpackage

`default_nettype wire

/* src/csvtok_front.sv */
// Front end: holds the delimiter register and classifies each input word.
// Depends on csvtok_pkg.
`default_nettype none

module csvtok_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [7:0]        cfg_wr_data,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,
  input  wire logic [1:0]        in_tuser,
  output logic                   push,
  output csvtok_pkg::token_t     push_tok,
  input  wire logic              q_ready
);
  import csvtok_pkg::*;

  logic [7:0] delim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
    end else if (cfg_wr_en) begin
      delim_r <= cfg_wr_data;
    end
  end

  assign in_tready = q_ready;
  assign push      = in_tvalid & q_ready;

  always_comb begin
    push_tok.kind     = kind_t'(in_tuser);
    push_tok.data     = in_tdata;
    push_tok.is_quote = (in_tdata == CH_QUOTE);
    push_tok.is_delim = (in_tdata == delim_r);
    push_tok.is_cr    = (in_tdata == CH_CR);
    push_tok.is_lf    = (in_tdata == CH_LF);
  end

endmodule

`default_nettype wire

/* src/csvtok_queue.sv */
// Short token queue between the classifier and the parser.
// Depends on csvtok_pkg.
`default_nettype none

module csvtok_queue #(
  parameter int DEPTH = csvtok_pkg::QDEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire csvtok_pkg::token_t push_tok,
  output logic                   q_ready,
  output logic                   q_valid,
  output csvtok_pkg::token_t     q_tok,
  input  wire logic              pop
);
  import csvtok_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  token_t            slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_ready = (count_r != CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_tok   = slot_r[rd_ptr_r];
  assign do_push = push & q_ready;
  assign do_pop  = pop & q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

`default_nettype wire

/* src/csvtok_back.sv */
// Back end: CSV parse state machine, row/column counters and output register.
// Depends on csvtok_pkg.
`default_nettype none

module csvtok_back #(
  parameter int ROW_BITS = csvtok_pkg::ROW_BITS_DEF,
  parameter int COL_BITS = csvtok_pkg::COL_BITS_DEF,
  parameter int DATA_W   = ((8 + ROW_BITS + COL_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire csvtok_pkg::token_t q_tok,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DATA_W-1:0]      out_tdata,
  output logic [1:0]             out_tuser
);
  import csvtok_pkg::*;

  localparam int PAD_W = DATA_W - 8 - ROW_BITS - COL_BITS;

  phase_t              phase_r, phase_nxt;
  logic [ROW_BITS:0]   lines_r, lines_nxt;
  logic [COL_BITS:0]   fields_r, fields_nxt;
  logic                pend_r, pend_nxt;

  logic                out_valid_r;
  event_t              ev_r;
  logic [7:0]          content_r;
  logic [ROW_BITS-1:0] row_r;
  logic [COL_BITS-1:0] col_r;

  logic                emit;
  event_t              ev;
  logic [7:0]          cont;
  logic [ROW_BITS-1:0] row_v;
  logic [COL_BITS-1:0] col_v;
  phase_t              ph;
  logic                done;
  logic                eol;

  assign pop = q_valid & (~out_valid_r | out_tready);
  assign eol = q_tok.is_cr | q_tok.is_lf;

  always_comb begin
    phase_nxt  = phase_r;
    lines_nxt  = lines_r;
    fields_nxt = fields_r;
    pend_nxt   = pend_r;
    emit       = 1'b0;
    ev         = EV_CONTENT;
    cont       = '0;
    ph         = phase_r;
    done       = 1'b0;
    if (pop) begin
      case (q_tok.kind)
        K_DATA: begin
          if (phase_r != PH_ERROR) begin
            if (ph == PH_AFTER_CR) begin
              if (q_tok.is_lf) begin
                phase_nxt = PH_LINE;
                done      = 1'b1;
              end else begin
                ph = PH_LINE;
              end
            end
            if (!done && ph == PH_LINE) begin
              if (!lines_r[ROW_BITS]) begin
                lines_nxt = lines_r + 1'b1;
              end
              fields_nxt = '0;
              if (eol) begin
                phase_nxt = q_tok.is_cr ? PH_AFTER_CR : PH_LINE;
                done      = 1'b1;
              end else begin
                ph = PH_FSTART;
              end
            end
            if (!done && ph == PH_FSTART) begin
              if (!fields_nxt[COL_BITS]) begin
                fields_nxt = fields_nxt + 1'b1;
              end
              pend_nxt = 1'b1;
              if (q_tok.is_quote) begin
                phase_nxt = PH_QUOTED;
                done      = 1'b1;
              end else begin
                ph = PH_PLAIN;
              end
            end
            if (!done) begin
              case (ph)
                PH_PLAIN: begin
                  if (q_tok.is_delim || eol) begin
                    emit = 1'b1;
                    ev   = EV_END;
                    if (q_tok.is_delim) begin
                      phase_nxt = PH_FSTART;
                      pend_nxt  = 1'b1;
                    end else begin
                      phase_nxt = q_tok.is_cr ? PH_AFTER_CR : PH_LINE;
                      pend_nxt  = 1'b0;
                    end
                  end else begin
                    phase_nxt = PH_PLAIN;
                    emit      = 1'b1;
                    cont      = q_tok.data;
                  end
                end
                PH_QUOTED: begin
                  if (q_tok.is_quote) begin
                    phase_nxt = PH_QSEEN;
                  end else begin
                    emit = 1'b1;
                    cont = q_tok.data;
                  end
                end
                PH_QSEEN: begin
                  if (q_tok.is_quote) begin
                    phase_nxt = PH_QUOTED;
                    emit      = 1'b1;
                    cont      = q_tok.data;
                  end else if (q_tok.is_delim || eol) begin
                    emit = 1'b1;
                    ev   = EV_END;
                    if (q_tok.is_delim) begin
                      phase_nxt = PH_FSTART;
                      pend_nxt  = 1'b1;
                    end else begin
                      phase_nxt = q_tok.is_cr ? PH_AFTER_CR : PH_LINE;
                      pend_nxt  = 1'b0;
                    end
                  end else begin
                    phase_nxt = PH_ERROR;
                    pend_nxt  = 1'b0;
                    emit      = 1'b1;
                    ev        = EV_ERROR;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        K_FINISH: begin
          if (phase_r != PH_ERROR) begin
            if (pend_r) begin
              if (phase_r == PH_FSTART && !fields_r[COL_BITS]) begin
                fields_nxt = fields_r + 1'b1;
              end
              emit = 1'b1;
              ev   = EV_END;
            end
            pend_nxt  = 1'b0;
            phase_nxt = PH_LINE;
          end
        end
        K_RESTART: begin
          phase_nxt  = PH_LINE;
          lines_nxt  = '0;
          fields_nxt = '0;
          pend_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    row_v = (lines_nxt == '0) ? '0 : ROW_BITS'(lines_nxt - 1'b1);
    col_v = (fields_nxt == '0) ? '0 : COL_BITS'(fields_nxt - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LINE;
      lines_r     <= '0;
      fields_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      lines_r  <= lines_nxt;
      fields_r <= fields_nxt;
      pend_r   <= pend_nxt;
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      ev_r      <= ev;
      content_r <= cont;
      row_r     <= row_v;
      col_r     <= col_v;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = ev_r;
  assign out_tdata  = {{PAD_W{1'b0}}, col_r, row_r, content_r};

endmodule

`default_nettype wire

/* src/csv_byte_tokenizer_core.sv */
// Top level of the CSV byte tokenizer: classifier, token queue and parser.
// Depends on csvtok_pkg, csvtok_front, csvtok_queue and csvtok_back.
//
//  channel  dir  tdata (low bit up)              tuser          handshake
//  in_      in   text_byte[7:0]                  kind[1:0]      tvalid/tready
//  out_     out  content, row, column, zero pad  event_res[1:0] tvalid/tready
//  cfg_     in   delimiter[7:0] on cfg_wr_data   -              cfg_wr_en
//
// One byte per cycle unless the output stalls; with the queue empty an accepted
// token goes to a queue slot and then the output register, as the parser reads
// the queue head directly. rst_n is synchronous: it empties the queue, returns
// the parser to line start and sets the delimiter to a comma. A stalled output
// holds its word while the queue keeps taking input until it fills.
`default_nettype none

module csv_byte_tokenizer_core #(
  parameter int ROW_BITS = csvtok_pkg::ROW_BITS_DEF,
  parameter int COL_BITS = csvtok_pkg::COL_BITS_DEF,
  parameter int QDEPTH   = csvtok_pkg::QDEPTH_DEF,
  parameter int DATA_W   = ((8 + ROW_BITS + COL_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [7:0]        cfg_wr_data,  // delimiter
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,     // text_byte
  input  wire logic [1:0]        in_tuser,     // kind
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DATA_W-1:0]      out_tdata,    // content, row, column, zeros
  output logic [1:0]             out_tuser     // event_res
);
  import csvtok_pkg::*;

  logic   push;
  token_t push_tok;
  logic   q_ready;
  logic   q_valid;
  token_t q_tok;
  logic   pop;

  csvtok_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .push        (push),
    .push_tok    (push_tok),
    .q_ready     (q_ready)
  );

  csvtok_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_tok    (q_tok),
    .pop      (pop)
  );

  csvtok_back #(
    .ROW_BITS (ROW_BITS),
    .COL_BITS (COL_BITS),
    .DATA_W   (DATA_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_tok      (q_tok),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_csv_byte_tokenizer_core.sv */
// Self-checking testbench for csv_byte_tokenizer_core: drives text words, finish and restart
// words under random stalls and checks every token word against an in-bench parser model.
// Depends on csvtok_pkg and csv_byte_tokenizer_core.
`default_nettype none

module tb_csv_byte_tokenizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import csvtok_pkg::*;

  localparam int ROW_BITS = ROW_BITS_DEF;
  localparam int COL_BITS = COL_BITS_DEF;
  localparam int DATA_W   = ((8 + ROW_BITS + COL_BITS + 7) / 8) * 8;
  localparam int ROW_LO   = 8;
  localparam int COL_LO   = 8 + ROW_BITS;
  localparam int PAD_LO   = COL_LO + COL_BITS;
  localparam logic [ROW_BITS:0] LINES_TOP  = {1'b1, {ROW_BITS{1'b0}}};
  localparam logic [COL_BITS:0] FIELDS_TOP = {1'b1, {COL_BITS{1'b0}}};
  localparam int PHASE_WORDS = 150;
  localparam int DRAIN_TAIL  = 12;

  typedef struct {
    event_t              ev;
    logic [7:0]          content;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] column;
  } token_exp_t;

  class tok_scoreboard;
    logic [7:0]        delim;
    phase_t            ph;
    logic [ROW_BITS:0] lines;
    logic [COL_BITS:0] fields;
    bit                owed;
    token_exp_t        expected_tokens[$];
    int                errors;
    int                checked;

    function void clear_parser();
      ph     = PH_LINE;
      lines  = '0;
      fields = '0;
      owed   = 1'b0;
    endfunction

    function void reset_all();
      delim = DELIM_RESET;
      clear_parser();
    endfunction

    function void post(event_t ev, logic [7:0] b);
      token_exp_t t;
      t.ev      = ev;
      t.content = (ev == EV_CONTENT) ? b : 8'h00;
      t.row     = (lines == 0) ? '0 : ROW_BITS'(lines - 1'b1);
      t.column  = (fields == 0) ? '0 : COL_BITS'(fields - 1'b1);
      expected_tokens.push_back(t);
    endfunction

    function void end_field(logic [7:0] b);
      post(EV_END, 8'h00);
      if (b == delim) begin
        ph   = PH_FSTART;
        owed = 1'b1;
      end else begin
        ph   = (b == CH_CR) ? PH_AFTER_CR : PH_LINE;
        owed = 1'b0;
      end
    endfunction

    function void take_byte(logic [7:0] b);
      phase_t p;
      bit     eol;
      p   = ph;
      eol = (b == CH_CR) || (b == CH_LF);
      if (p == PH_ERROR) return;
      if (p == PH_AFTER_CR) begin
        if (b == CH_LF) begin
          ph = PH_LINE;
          return;
        end
        p = PH_LINE;
      end
      if (p == PH_LINE) begin
        if (lines < LINES_TOP) lines = lines + 1'b1;
        fields = '0;
        if (eol) begin
          ph = (b == CH_CR) ? PH_AFTER_CR : PH_LINE;
          return;
        end
        p = PH_FSTART;
      end
      if (p == PH_FSTART) begin
        if (fields < FIELDS_TOP) fields = fields + 1'b1;
        owed = 1'b1;
        if (b == CH_QUOTE) begin
          ph = PH_QUOTED;
          return;
        end
        p = PH_PLAIN;
      end
      if (p == PH_PLAIN) begin
        if (b == delim || eol) begin
          end_field(b);
        end else begin
          ph = PH_PLAIN;
          post(EV_CONTENT, b);
        end
      end else if (p == PH_QUOTED) begin
        if (b == CH_QUOTE) ph = PH_QSEEN;
        else post(EV_CONTENT, b);
      end else begin
        if (b == CH_QUOTE) begin
          ph = PH_QUOTED;
          post(EV_CONTENT, b);
        end else if (b == delim || eol) begin
          end_field(b);
        end else begin
          ph   = PH_ERROR;
          owed = 1'b0;
          post(EV_ERROR, 8'h00);
        end
      end
    endfunction

    function void take_finish();
      if (ph == PH_ERROR) return;
      if (owed) begin
        if (ph == PH_FSTART && fields < FIELDS_TOP) fields = fields + 1'b1;
        post(EV_END, 8'h00);
      end
      owed = 1'b0;
      ph   = PH_LINE;
    endfunction

    function void note_word(logic [1:0] k, logic [7:0] b);
      case (k)
        K_DATA:    take_byte(b);
        K_FINISH:  take_finish();
        K_RESTART: clear_parser();
        default: ;
      endcase
    endfunction

    function void compare(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_word(logic [1:0] ev, logic [DATA_W-1:0] d);
      token_exp_t t;
      if (expected_tokens.size() == 0) begin
        errors++;
        $display("%0t: unexpected token word, expected none actual ev=%0d data=%h",
                 $time, ev, d);
        return;
      end
      t = expected_tokens.pop_front();
      checked++;
      compare("event", t.ev, ev);
      compare("content", t.content, d[7:0]);
      compare("row", t.row, d[ROW_LO +: ROW_BITS]);
      compare("column", t.column, d[COL_LO +: COL_BITS]);
      compare("pad", 0, d[DATA_W-1:PAD_LO]);
    endfunction

    function void flag_leftovers();
      if (expected_tokens.size() != 0) begin
        errors += expected_tokens.size();
        $display("%0t: %0d token words expected but never seen", $time,
                 expected_tokens.size());
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [7:0]        cfg_wr_data = 8'h00;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata    = 8'h00;
  logic [1:0]        in_tuser    = 2'b00;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic [1:0]        out_tuser;

  tok_scoreboard sb = new();
  bit            calm = 1'b0;
  int            hold_cnt = 0;
  int            words_sent = 0;
  int            delim_settings = 0;

  csv_byte_tokenizer_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        out_tready <= 1'b0;
        hold_cnt--;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 28);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tuser, out_tdata);
  end

  task automatic push_word(input logic [1:0] k, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(k, b);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(K_DATA, s[i]);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (sb.expected_tokens.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic cfg_load(input logic [7:0] d);
    cfg_wr_data <= d;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    sb.delim = d;
    cfg_wr_en <= 1'b0;
    delim_settings++;
  endtask

  function automatic logic [7:0] plain_char(input logic [7:0] d);
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == CH_QUOTE || c == d || c == CH_CR || c == CH_LF) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] quoted_char(input logic [7:0] d);
    int r;
    r = $urandom_range(99);
    if (r < 15) return CH_QUOTE;
    if (r < 25) return d;
    if (r < 32) return CH_CR;
    if (r < 38) return CH_LF;
    return 8'($urandom_range(255));
  endfunction

  task automatic gen_row();
    int         nf;
    int         len;
    int         r;
    bit         q;
    logic [7:0] c;
    if ($urandom_range(99) < 8) push_word(K_RESTART, 8'($urandom_range(255)));
    nf = $urandom_range(4, 1);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) push_word(K_DATA, sb.delim);
      q = ($urandom_range(99) < 35);
      if (q) push_word(K_DATA, CH_QUOTE);
      len = $urandom_range(5);
      for (int j = 0; j < len; j++) begin
        c = q ? quoted_char(sb.delim) : plain_char(sb.delim);
        push_word(K_DATA, c);
        if (q && c == CH_QUOTE) push_word(K_DATA, CH_QUOTE);
      end
      if (q) begin
        if ($urandom_range(99) < 90) push_word(K_DATA, CH_QUOTE);
        if ($urandom_range(99) < 6) push_word(K_DATA, 8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 4) push_word(2'($urandom_range(3)), 8'($urandom_range(255)));
    end
    r = $urandom_range(99);
    if (r < 35) begin
      push_word(K_DATA, CH_LF);
    end else if (r < 65) begin
      push_word(K_DATA, CH_CR);
    end else if (r < 85) begin
      push_word(K_DATA, CH_CR);
      push_word(K_DATA, CH_LF);
    end else if (r < 95) begin
      push_word(K_FINISH, 8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 5) push_word(K_DATA, CH_LF);
  endtask

  initial begin
    logic [7:0] delims[8];
    int         phase_start;
    delims = '{8'h00, 8'hFF, CH_QUOTE, CH_CR, CH_LF, 8'h09, 8'h3B, DELIM_RESET};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    sb.reset_all();
    @(posedge clk);

    send_text("a,\"x\"\"y,");
    push_word(K_DATA, CH_CR);
    push_word(K_DATA, CH_QUOTE);
    push_word(K_DATA, CH_CR);
    push_word(K_DATA, CH_LF);
    push_word(K_DATA, CH_LF);
    send_text("\"q\"zk");
    push_word(K_FINISH, 8'h00);
    push_word(K_RESTART, 8'h00);
    push_word(K_DATA, 8'h00);
    push_word(K_DATA, 8'hFF);
    push_word(K_UNUSED, 8'hA5);
    push_word(K_DATA, ",");
    push_word(K_FINISH, 8'h00);
    send_text("\"b\"");
    push_word(K_FINISH, 8'h00);
    send_text("\"a");
    push_word(K_FINISH, 8'h00);
    drain();

    foreach (delims[i]) begin
      cfg_load(delims[i]);
      if (i == 0 || i == 6) hold_cnt = 300;
      calm = (i == 4);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) gen_row();
      drain();
    end
    calm = 1'b0;

    sb.flag_leftovers();
    $display("Sent %0d input words over %0d delimiter settings, checked %0d token words,",
             words_sent, delim_settings, sb.checked);
    $display("including quoted, empty-line, error, finish and restart cases under stalls.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
